// ===== sv/msk_pkg.sv =====
// Shared constants, codes and item types for the running-minimum stack.
`default_nettype none
package msk_pkg;
	// Storage geometry
	localparam int STACK_DEPTH = 256;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

	// Operation codes
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_EMPTY_POP = 2'd1;
	localparam logic [1:0] ERR_FULL_PUSH = 2'd2;

	// Request item
	typedef struct packed {
		logic        [1:0]             operation;
		logic signed [VALUE_WIDTH-1:0] push_value;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] top_value;
		logic signed [VALUE_WIDTH-1:0] min_value;
		logic        [COUNT_W-1:0]     entry_count;
		logic                          is_empty;
		logic        [1:0]             error_code;
	} out_item_t;

	// One stack entry: value and minimum at or below its level
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic signed [VALUE_WIDTH-1:0] minimum;
	} entry_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       push_en;    // write entry, raise count
		logic       pop_en;     // lower count
		logic       fetch_en;   // read the entry that becomes the new top
		logic       refill_en;  // load cached top from read data
		logic       result_en;  // capture the result item
		logic [1:0] err;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic single;
	} dp_status_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_FILL = 2'b10
	} ctrl_state_t;
endpackage
`default_nettype wire

// ===== sv/msk_ctrl.sv =====
// Controller: handshakes, operation decode and the pop refill sequence.
`default_nettype none
module msk_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            operation,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire msk_pkg::dp_status_t   status,
	output msk_pkg::ctrl_cmd_t         cmd
);
	msk_pkg::ctrl_state_t state_q, state_d;
	logic out_valid_q;
	logic accept;

	// Take an item only when idle and the result register is free or draining
	assign in_ready  = (state_q == msk_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Decode and sequencing
	always_comb begin
		cmd     = '0;
		cmd.err = msk_pkg::ERR_OK;
		state_d = state_q;
		case (state_q)
			msk_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.result_en = 1'b1;
					if (operation == msk_pkg::OP_PUSH) begin
						if (status.full) begin
							cmd.err = msk_pkg::ERR_FULL_PUSH;
						end else begin
							cmd.push_en = 1'b1;
						end
					end else if (operation == msk_pkg::OP_POP) begin
						if (status.empty) begin
							cmd.err = msk_pkg::ERR_EMPTY_POP;
						end else begin
							cmd.pop_en = 1'b1;
							if (!status.single) begin
								// new top lives in memory: result waits for the refill in ST_FILL
								cmd.fetch_en  = 1'b1;
								cmd.result_en = 1'b0;
								state_d       = msk_pkg::ST_FILL;
							end
						end
					end
				end
			end
			msk_pkg::ST_FILL: begin
				cmd.refill_en = 1'b1;
				cmd.result_en = 1'b1;
				state_d       = msk_pkg::ST_IDLE;
			end
			default: begin
				state_d = msk_pkg::ST_IDLE;
			end
		endcase
	end

	// State and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msk_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/msk_datapath.sv =====
// Datapath: entry memory, cached top and minimum, fill count, result register.
`default_nettype none
module msk_datapath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic signed [msk_pkg::VALUE_WIDTH-1:0] push_value,
	input  wire msk_pkg::ctrl_cmd_t                   cmd,
	output msk_pkg::dp_status_t                       status,
	output msk_pkg::out_item_t                        out_data
);
	msk_pkg::entry_t entry_mem [msk_pkg::STACK_DEPTH];
	msk_pkg::entry_t rd_q;
	msk_pkg::entry_t new_entry;
	msk_pkg::out_item_t result_q;

	logic        [msk_pkg::COUNT_W-1:0]     count_q, count_d;
	logic signed [msk_pkg::VALUE_WIDTH-1:0] top_q, top_d;
	logic signed [msk_pkg::VALUE_WIDTH-1:0] min_q, min_d;
	logic        [msk_pkg::ADDR_W-1:0]      wr_addr, rd_addr;
	logic        [msk_pkg::COUNT_W-1:0]     below_top;

	// Status for the controller
	assign status.empty  = (count_q == '0);
	assign status.full   = (count_q == msk_pkg::COUNT_W'(msk_pkg::STACK_DEPTH));
	assign status.single = (count_q == msk_pkg::COUNT_W'(1));

	// New entry: its minimum folds in the level below (cached in min_q)
	always_comb begin
		new_entry.value   = push_value;
		new_entry.minimum = (status.empty || (push_value < min_q)) ? push_value : min_q;
	end

	assign wr_addr   = count_q[msk_pkg::ADDR_W-1:0];
	assign below_top = count_q - msk_pkg::COUNT_W'(2);
	assign rd_addr   = below_top[msk_pkg::ADDR_W-1:0];

	// Next cached top, minimum and count
	always_comb begin
		count_d = count_q;
		top_d   = top_q;
		min_d   = min_q;
		if (cmd.push_en) begin
			count_d = count_q + msk_pkg::COUNT_W'(1);
			top_d   = new_entry.value;
			min_d   = new_entry.minimum;
		end
		if (cmd.pop_en) begin
			count_d = count_q - msk_pkg::COUNT_W'(1);
		end
		if (cmd.refill_en) begin
			top_d = rd_q.value;
			min_d = rd_q.minimum;
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Cached top entry
	always_ff @(posedge clk) begin
		top_q <= top_d;
		min_q <= min_d;
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.push_en) begin
			entry_mem[wr_addr] <= new_entry;
		end
		if (cmd.fetch_en) begin
			rd_q <= entry_mem[rd_addr];
		end
	end

	// Result register, state after the item
	always_ff @(posedge clk) begin
		if (cmd.result_en) begin
			result_q.top_value   <= (count_d == '0) ? '0 : top_d;
			result_q.min_value   <= (count_d == '0) ? '0 : min_d;
			result_q.entry_count <= count_d;
			result_q.is_empty    <= (count_d == '0);
			result_q.error_code  <= cmd.err;
		end
	end

	assign out_data = result_q;
endmodule
`default_nettype wire

// ===== sv/stack_with_running_minimum_top.sv =====
// Top level of the stack with running minimum.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one item: an operation
//   (push, pop or read only) and the value to push. Output channel
//   out_valid/out_ready/out_data returns exactly one result item per input
//   item: top value, minimum, entry count, empty flag and error code, all
//   describing the stack after that item. Top and minimum read zero when
//   the stack is empty. A pop on empty or a push on full is flagged and
//   leaves the stack unchanged.
// Timing:
//   Push, read and an error item have their result registered at accept.
//   A pop that leaves entries behind passes through a refill state: the new
//   top comes from the single registered read port of the entry memory,
//   and no new item is taken then. Else one item per cycle, unless stalled.
// Reset:
//   arst_n clears the fill count and the controller; the stack is empty.
// Stall:
//   A waiting result sits in the output register; one more item is taken
//   only in the cycle that result is drained, otherwise in_ready stays low.
`default_nettype none
module stack_with_running_minimum_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire msk_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output msk_pkg::out_item_t      out_data
);
	msk_pkg::ctrl_cmd_t  cmd;
	msk_pkg::dp_status_t status;

	// Controller
	msk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (in_data.operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath
	msk_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_value (in_data.push_value),
		.cmd        (cmd),
		.status     (status),
		.out_data   (out_data)
	);
endmodule
`default_nettype wire

// ===== sv/msk_checker.sv =====
// Port-level checker for the running-minimum stack, bound to the top level.
`default_nettype none
module msk_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire msk_pkg::in_item_t  in_data,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire msk_pkg::out_item_t out_data
);
	// A waiting request item holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request item changed while waiting");

	// A stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	// Empty flag agrees with the count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.is_empty == (out_data.entry_count == '0)))
		else $error("empty flag disagrees with entry count");

	// Empty stack reads zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_empty |->
			(out_data.top_value == '0) && (out_data.min_value == '0))
		else $error("empty stack result not zero");

	// Minimum never exceeds the top entry
	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_empty |-> (out_data.min_value <= out_data.top_value))
		else $error("minimum above top value");
endmodule

bind stack_with_running_minimum_top msk_checker u_msk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

// ===== bench/min_stack_checker.sv =====
// Checker for the running-minimum stack: predicts each result item and compares it.
`timescale 1ns / 1ps
module min_stack_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  msk_pkg::in_item_t           in_data,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  msk_pkg::out_item_t          out_data,
	output int                          mismatch_count,
	output int                          results_pending
);
	// Predicted stack contents: value and minimum at or below each level
	logic signed [msk_pkg::VALUE_WIDTH-1:0] held_value   [msk_pkg::STACK_DEPTH];
	logic signed [msk_pkg::VALUE_WIDTH-1:0] held_minimum [msk_pkg::STACK_DEPTH];
	int unsigned                            depth_used;
	msk_pkg::out_item_t                     expected_results [$];

	// Apply one item to the predicted stack and return the result it gives
	function automatic msk_pkg::out_item_t apply_to_stack(msk_pkg::in_item_t item);
		msk_pkg::out_item_t                     res;
		logic signed [msk_pkg::VALUE_WIDTH-1:0] level_min;
		res = '0;
		res.error_code = msk_pkg::ERR_OK;
		if (item.operation == msk_pkg::OP_PUSH) begin
			if (depth_used >= msk_pkg::STACK_DEPTH) begin
				res.error_code = msk_pkg::ERR_FULL_PUSH;
			end else begin
				level_min = item.push_value;
				// ties keep the old minimum, which is the same value
				if (depth_used > 0 && !(item.push_value < held_minimum[depth_used - 1]))
					level_min = held_minimum[depth_used - 1];
				held_value[depth_used]   = item.push_value;
				held_minimum[depth_used] = level_min;
				depth_used++;
			end
		end else if (item.operation == msk_pkg::OP_POP) begin
			if (depth_used == 0)
				res.error_code = msk_pkg::ERR_EMPTY_POP;
			else
				depth_used--;
		end
		// read only and the unused code leave the stack alone
		if (depth_used > 0) begin
			res.top_value = held_value[depth_used - 1];
			res.min_value = held_minimum[depth_used - 1];
		end
		res.entry_count = msk_pkg::COUNT_W'(depth_used);
		res.is_empty    = (depth_used == 0);
		return res;
	endfunction

	// Field-by-field compare, one report per bad field
	task automatic check_result(msk_pkg::out_item_t want, msk_pkg::out_item_t got);
		if (got.top_value !== want.top_value) begin
			$display("%0t: top_value expected %0d got %0d", $time, want.top_value,
				got.top_value);
			mismatch_count++;
		end
		if (got.min_value !== want.min_value) begin
			$display("%0t: min_value expected %0d got %0d", $time, want.min_value,
				got.min_value);
			mismatch_count++;
		end
		if (got.entry_count !== want.entry_count) begin
			$display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
				got.entry_count);
			mismatch_count++;
		end
		if (got.is_empty !== want.is_empty) begin
			$display("%0t: is_empty expected %0b got %0b", $time, want.is_empty,
				got.is_empty);
			mismatch_count++;
		end
		if (got.error_code !== want.error_code) begin
			$display("%0t: error_code expected %0d got %0d", $time, want.error_code,
				got.error_code);
			mismatch_count++;
		end
	endtask

	// Watch both channels; results are checked before the new item is predicted
	always @(posedge clk or negedge arst_n) begin
		msk_pkg::out_item_t want;
		if (!arst_n) begin
			depth_used      = 0;
			mismatch_count  = 0;
			results_pending = 0;
			expected_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result item with none expected, got %h", $time, out_data);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_result(want, out_data);
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(apply_to_stack(in_data));
			results_pending = expected_results.size();
		end
	end
endmodule

// ===== bench/stack_with_running_minimum_top_test.sv =====
// Stimulus and verdict for the running-minimum stack.
`timescale 1ns / 1ps
module stack_with_running_minimum_top_test;
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         ITEM_TARGET = 1250;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	msk_pkg::in_item_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	msk_pkg::out_item_t out_data;
	logic               in_taken  = 1'b0;
	int                 mismatch_count;
	int                 results_pending;
	int                 items_sent  = 0;
	int                 stack_level = 0;
	bit                 quiet_input = 1'b0;

	stack_with_running_minimum_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	min_stack_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.mismatch_count (mismatch_count),
		.results_pending(results_pending)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Handshake seen at the rising edge, read back at the falling edge
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
	end

	// Idle lengths: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 2);
		if (r < 97) return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	// Values: extremes, a narrow band for ties, or anything
	function automatic logic signed [msk_pkg::VALUE_WIDTH-1:0] random_value();
		int r;
		int narrow;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0:       return {1'b0, {(msk_pkg::VALUE_WIDTH - 1){1'b1}}};
				1:       return {1'b1, {(msk_pkg::VALUE_WIDTH - 1){1'b0}}};
				2:       return '1;
				default: return '0;
			endcase
		end
		if (r < 4) begin
			narrow = int'($urandom_range(0, 15)) - 8;
			return msk_pkg::VALUE_WIDTH'(narrow);
		end
		return msk_pkg::VALUE_WIDTH'($urandom);
	endfunction

	function automatic logic [1:0] random_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return msk_pkg::OP_PUSH;
		if (r < 80) return msk_pkg::OP_POP;
		if (r < 95) return msk_pkg::OP_READ;
		return OP_UNUSED;
	endfunction

	// Present one item at a falling edge and hold it until taken
	task automatic send_item(logic [1:0] op, logic signed [msk_pkg::VALUE_WIDTH-1:0] value);
		int                gap;
		msk_pkg::in_item_t item;
		gap = quiet_input ? 0 : pick_gap();
		if (gap > 0) begin
			if (in_valid)
				in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.operation  = op;
		item.push_value = value;
		in_valid <= 1'b1;
		in_data  <= item;
		do @(negedge clk); while (!in_taken);
		items_sent++;
		// level kept only to shape the stimulus
		if (op == msk_pkg::OP_PUSH && stack_level < msk_pkg::STACK_DEPTH)
			stack_level++;
		else if (op == msk_pkg::OP_POP && stack_level > 0)
			stack_level--;
	endtask

	// Result side: random stalls, with long stretches always ready
	initial begin
		int run;
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 4) == 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(50, 200)) @(negedge clk);
			end else begin
				run = pick_gap();
				if (run > 0) begin
					out_ready <= 1'b0;
					repeat (run) @(negedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	end

	// Main stimulus
	initial begin
		int pick;
		int count;
		int segment;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty reads, extremes, ties, unused code, drain past empty
		send_item(msk_pkg::OP_READ, '0);
		send_item(msk_pkg::OP_POP, '1);
		send_item(msk_pkg::OP_PUSH, {1'b0, {(msk_pkg::VALUE_WIDTH - 1){1'b1}}});
		send_item(msk_pkg::OP_PUSH, 32'sd5);
		send_item(msk_pkg::OP_PUSH, 32'sd5);
		send_item(msk_pkg::OP_PUSH, {1'b1, {(msk_pkg::VALUE_WIDTH - 1){1'b0}}});
		send_item(msk_pkg::OP_PUSH, {1'b1, {(msk_pkg::VALUE_WIDTH - 1){1'b0}}});
		send_item(msk_pkg::OP_PUSH, '0);
		send_item(msk_pkg::OP_READ, '1);
		send_item(OP_UNUSED, 32'sd77);
		repeat (6) send_item(msk_pkg::OP_POP, '0);
		send_item(msk_pkg::OP_POP, '0);
		send_item(OP_UNUSED, '0);
		send_item(msk_pkg::OP_PUSH, '1);
		send_item(msk_pkg::OP_PUSH, 32'sd1);
		send_item(msk_pkg::OP_PUSH, -32'sd1);
		send_item(msk_pkg::OP_POP, '0);
		send_item(msk_pkg::OP_POP, '0);
		send_item(msk_pkg::OP_POP, '0);

		// Random: runs to full, drains to empty, and mixed bursts
		segment = 0;
		while (items_sent < ITEM_TARGET) begin
			pick        = $urandom_range(0, 11);
			quiet_input = ($urandom_range(0, 3) == 0);
			if (segment == 0 || pick == 0) begin
				count = msk_pkg::STACK_DEPTH - stack_level + $urandom_range(1, 3);
				repeat (count) send_item(msk_pkg::OP_PUSH, random_value());
			end else if (pick == 1) begin
				count = stack_level + $urandom_range(1, 3);
				repeat (count) send_item(msk_pkg::OP_POP, random_value());
			end else begin
				repeat ($urandom_range(20, 60)) send_item(random_op(), random_value());
			end
			segment++;
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then let the block settle
		while (results_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Hard stop
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== stack_with_running_minimum_top.f =====
sv/msk_pkg.sv
sv/msk_ctrl.sv
sv/msk_datapath.sv
sv/stack_with_running_minimum_top.sv
sv/msk_checker.sv
bench/min_stack_checker.sv
bench/stack_with_running_minimum_top_test.sv
